### hw/rtl/jmsc_pkg.sv
package jmsc_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [7:0] CenterVal = 8'd128;
  localparam logic [7:0] FullDuty  = 8'd255;
  localparam logic [7:0] AngleMax  = 8'd180;

  localparam logic [6:0] DeadZoneRst  = 7'd30;
  localparam logic [7:0] RampStepRst  = 8'd5;
  localparam logic [7:0] HomeAngleRst = 8'd90;

  typedef enum logic [1:0] {
    RegDeadZone  = 2'd0,
    RegRampStep  = 2'd1,
    RegHomeAngle = 2'd2,
    RegNone      = 2'd3
  } jmsc_reg_e;

  typedef struct packed {
    logic       link_present;
    logic       click_open;
    logic       click_close;
    logic       click_stop;
    logic       click_estop;
    logic       click_home;
    logic [7:0] speed_stick;
    logic [7:0] servo_a_stick;
    logic [7:0] servo_b_stick;
  } jmsc_req_t;

  typedef struct packed {
    logic       bridge_in1;
    logic       bridge_in2;
    logic [7:0] pwm_duty;
    logic       bridge_enable;
    logic [7:0] servo_a_angle;
    logic [7:0] servo_b_angle;
    logic       run_mode;
  } jmsc_rsp_t;

  typedef struct packed {
    logic [6:0] dead_zone;
    logic [7:0] ramp_step;
    logic [7:0] home_angle;
  } jmsc_cfg_t;

  typedef struct packed {
    logic       link_seen;
    logic       mode;
    logic [7:0] target_duty;
    logic [7:0] present_duty;
    logic       open_dir;
    logic [7:0] servo_a_pos;
    logic [7:0] servo_b_pos;
    logic       pin_one;
    logic       pin_two;
  } jmsc_state_t;

endpackage

### hw/rtl/joystick_motor_servo_commander.sv
// An accepted request waits in the request register, then moves to the result register (which
// drives out_valid_o) once that is empty or being drained. Throughput: one request per cycle
// while out_ready_i is high; the request and result registers form a two-stage pipe, and the
// controller state is updated in the single cycle that moves a request between them.
// Reset (rst_ni low, asynchronous): pipe empty, idle mode, duties zero, servos at 90,
// registers back to dead zone 30, ramp step 5, home angle 90.
module joystick_motor_servo_commander (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  jmsc_pkg::jmsc_req_t         req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output jmsc_pkg::jmsc_rsp_t         rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jmsc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import jmsc_pkg::*;

  jmsc_cfg_t   cfg;
  jmsc_req_t   req_q;
  logic        req_vld_q;
  jmsc_rsp_t   rsp_q, rsp_d;
  logic        rsp_vld_q;
  jmsc_state_t state_q, state_d;
  logic        advance;

  jmsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jmsc_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .req_i   (req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  assign advance    = req_vld_q && (!rsp_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_vld_q <= in_valid_i;
      end
      if (advance) begin
        rsp_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.link_seen    <= 1'b0;
      state_q.mode         <= 1'b0;
      state_q.target_duty  <= 8'd0;
      state_q.present_duty <= 8'd0;
      state_q.open_dir     <= 1'b1;
      state_q.servo_a_pos  <= HomeAngleRst;
      state_q.servo_b_pos  <= HomeAngleRst;
      state_q.pin_one      <= 1'b0;
      state_q.pin_two      <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  // mode and link tracking always move together
  a_mode_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == state_q.link_seen)
    else $error("mode and link_seen disagree");

  // idle controller holds the motor stopped
  a_idle_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.mode |-> (state_q.present_duty == 8'd0 && state_q.target_duty == 8'd0))
    else $error("motor duty nonzero while idle");

  // once driven, bridge pins are never both high or both low
  a_pins_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pin_one || state_q.pin_two) |-> (state_q.pin_one != state_q.pin_two))
    else $error("bridge pins not complementary");

  a_enable_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> (rsp_q.bridge_enable == (rsp_q.pwm_duty != 8'd0)))
    else $error("bridge enable does not match duty");

  // controller state only moves when a request is retired
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a request");

endmodule

### hw/rtl/jmsc_regs.sv
module jmsc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jmsc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output jmsc_pkg::jmsc_cfg_t          cfg_o
);
  import jmsc_pkg::*;

  jmsc_cfg_t cfg_q, cfg_d;
  jmsc_reg_e sel;
  logic      wr_en;

  assign pready = 1'b1;
  assign sel    = jmsc_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegDeadZone:  cfg_d.dead_zone  = pwdata[6:0];
        RegRampStep:  cfg_d.ramp_step  = pwdata[7:0];
        RegHomeAngle: cfg_d.home_angle = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegDeadZone:  prdata = {25'd0, cfg_q.dead_zone};
      RegRampStep:  prdata = {24'd0, cfg_q.ramp_step};
      RegHomeAngle: prdata = {24'd0, cfg_q.home_angle};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone  <= DeadZoneRst;
      cfg_q.ramp_step  <= RampStepRst;
      cfg_q.home_angle <= HomeAngleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/jmsc_step.sv
module jmsc_step (
  input  jmsc_pkg::jmsc_state_t state_i,
  input  jmsc_pkg::jmsc_cfg_t   cfg_i,
  input  jmsc_pkg::jmsc_req_t   req_i,
  output jmsc_pkg::jmsc_state_t state_o,
  output jmsc_pkg::jmsc_rsp_t   rsp_o
);
  import jmsc_pkg::*;

  function automatic logic stick_active(logic [7:0] s, logic [6:0] dz);
    logic [7:0] dev;
    dev = (s >= CenterVal) ? (s - CenterVal) : (CenterVal - s);
    return dev > {1'b0, dz};
  endfunction

  // s*180/255: x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
  function automatic logic [7:0] stick_to_angle(logic [7:0] s);
    logic [15:0] p;
    logic [16:0] sum;
    p   = 16'(s) * 16'(AngleMax);
    sum = 17'(p) + 17'(p[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  function automatic logic [7:0] clamp_angle(logic [7:0] a);
    return (a > AngleMax) ? AngleMax : a;
  endfunction

  jmsc_state_t st;
  logic [8:0]  twice;
  logic [8:0]  up;
  logic [7:0]  down;

  always_comb begin
    st    = state_i;
    twice = {req_i.speed_stick, 1'b0};
    up    = 9'(st.present_duty) + 9'(cfg_i.ramp_step);
    down  = 8'd0;
    if (req_i.link_present) begin
      if (!st.link_seen) begin
        st.link_seen = 1'b1;
        st.mode      = 1'b1;
      end
      if (req_i.click_open) begin
        st.target_duty = FullDuty;
        st.open_dir    = 1'b1;
      end
      if (req_i.click_close) begin
        st.target_duty = FullDuty;
        st.open_dir    = 1'b0;
      end
      if (req_i.click_stop) begin
        st.target_duty = 8'd0;
      end
      if (stick_active(req_i.speed_stick, cfg_i.dead_zone)) begin
        if (twice > 9'(FullDuty)) begin
          st.target_duty = 8'(twice - 9'(FullDuty));
          st.open_dir    = 1'b1;
        end else begin
          st.target_duty = 8'(9'(FullDuty) - twice);
          st.open_dir    = 1'b0;
        end
      end
      if (stick_active(req_i.servo_a_stick, cfg_i.dead_zone)) begin
        st.servo_a_pos = stick_to_angle(req_i.servo_a_stick);
      end
      if (stick_active(req_i.servo_b_stick, cfg_i.dead_zone)) begin
        st.servo_b_pos = stick_to_angle(req_i.servo_b_stick);
      end
      if (req_i.click_estop) begin
        st.target_duty  = 8'd0;
        st.present_duty = 8'd0;
      end
      if (req_i.click_home) begin
        st.servo_a_pos = cfg_i.home_angle;
        st.servo_b_pos = cfg_i.home_angle;
        st.target_duty = 8'd0;
      end
      // slew toward target
      up = 9'(st.present_duty) + 9'(cfg_i.ramp_step);
      if (st.present_duty > cfg_i.ramp_step) begin
        down = st.present_duty - cfg_i.ramp_step;
      end
      if (st.present_duty < st.target_duty) begin
        st.present_duty = (up < 9'(st.target_duty)) ? up[7:0] : st.target_duty;
      end else if (st.present_duty > st.target_duty) begin
        st.present_duty = (down > st.target_duty) ? down : st.target_duty;
      end
      st.pin_one = st.open_dir;
      st.pin_two = ~st.open_dir;
    end else if (st.link_seen) begin
      st.link_seen    = 1'b0;
      st.mode         = 1'b0;
      st.target_duty  = 8'd0;
      st.present_duty = 8'd0;
      st.pin_one      = 1'b1;
      st.pin_two      = 1'b0;
    end
  end

  assign state_o = st;

  assign rsp_o.bridge_in1    = st.pin_one;
  assign rsp_o.bridge_in2    = st.pin_two;
  assign rsp_o.pwm_duty      = st.present_duty;
  assign rsp_o.bridge_enable = (st.present_duty != 8'd0);
  assign rsp_o.servo_a_angle = clamp_angle(st.servo_a_pos);
  assign rsp_o.servo_b_angle = clamp_angle(st.servo_b_pos);
  assign rsp_o.run_mode      = st.mode;

endmodule
